// ===== rtl/ccp_pkg.sv =====
package ccp_pkg;

    localparam int COORD_W   = 24;
    localparam int RAD_W     = 23;
    localparam int DIFF_W    = 26;
    localparam int MAG_W     = 25;
    localparam int RSUM_W    = 24;
    localparam int SQ_W      = 51;
    localparam int RADICAND_W = 48;
    localparam int ROOT_W    = 24;
    localparam int PROD_W    = 49;
    localparam int DIVIDEND_W = 50;
    localparam int QUOT_W    = 24;
    localparam int PUSH_W    = 25;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = QUOT_W;

    localparam int S_TDATA_W = 192;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    typedef struct packed {
        logic [MAG_W-1:0]  ax;
        logic [MAG_W-1:0]  ay;
        logic              neg_x;
        logic              neg_y;
        logic [RSUM_W-1:0] rsum;
        logic              hit;
        logic              degen;
    } ccp_root_side_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic hit;
        logic degen;
    } ccp_div_side_t;

endpackage

// ===== rtl/circle_circle_collision_push_top.sv =====
// Circle pair overlap test with push-back vector. One pair enters per clock and its
// result passes three front stages, a 24-stage bit-per-stage square root, three
// scaling stages, a 24-stage restoring divider per axis and an output register.
// The pipeline stalls as a whole only when the output skid register is full;
// s_tready is registered. m_tuser carries colliding and degenerate; push is
// zero unless the circles overlap with distinct centres.
module circle_circle_collision_push_top
    import ccp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // first_x, first_y, first_radius, second_x, second_y, second_radius,
    // offset_x, offset_y, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // push_x, push_y, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // colliding, degenerate
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int DEPTH = 3 + SQRT_STAGES + 3 + DIV_STAGES + 1;
    localparam int V_S3  = 2;
    localparam int V_SQ  = V_S3 + SQRT_STAGES;
    localparam int V_N   = V_SQ + 3;

    logic             en;
    logic [DEPTH-1:0] valid_reg;
    logic             skid_full_reg;
    logic [M_TDATA_W-1:0] skid_data_reg;
    logic [M_TUSER_W-1:0] skid_user_reg;

    assign en       = !skid_full_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DEPTH-2:0], s_tvalid};
        end
    end

    logic signed [COORD_W-1:0] fx, fy, sx, sy, ox, oy;
    logic [RAD_W-1:0]          fr, sr;
    assign fx = s_tdata[23:0];
    assign fy = s_tdata[47:24];
    assign fr = s_tdata[70:48];
    assign sx = s_tdata[94:71];
    assign sy = s_tdata[118:95];
    assign sr = s_tdata[141:119];
    assign ox = s_tdata[165:142];
    assign oy = s_tdata[189:166];

    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [RSUM_W-1:0]        rsum1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg    <= DIFF_W'(sx) + DIFF_W'(ox) - DIFF_W'(fx);
            dy_reg    <= DIFF_W'(sy) + DIFF_W'(oy) - DIFF_W'(fy);
            rsum1_reg <= RSUM_W'(fr) + RSUM_W'(sr);
        end
    end

    logic [DIFF_W-1:0] adx, ady;
    assign adx = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
    assign ady = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);

    logic [2*MAG_W-1:0]  sqx_reg, sqy_reg;
    logic [2*RSUM_W-1:0] rs2_reg;
    ccp_root_side_t      side2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg         <= adx[MAG_W-1:0] * adx[MAG_W-1:0];
            sqy_reg         <= ady[MAG_W-1:0] * ady[MAG_W-1:0];
            rs2_reg         <= rsum1_reg * rsum1_reg;
            side2_reg.ax    <= adx[MAG_W-1:0];
            side2_reg.ay    <= ady[MAG_W-1:0];
            side2_reg.neg_x <= dx_reg[DIFF_W-1];
            side2_reg.neg_y <= dy_reg[DIFF_W-1];
            side2_reg.rsum  <= rsum1_reg;
            side2_reg.hit   <= 1'b0;
            side2_reg.degen <= (dx_reg == '0) && (dy_reg == '0);
        end
    end

    logic [SQ_W-1:0]       sq;
    logic [RADICAND_W-1:0] radicand_reg;
    ccp_root_side_t        side3_reg;
    ccp_root_side_t        side3_next;
    assign sq = SQ_W'(sqx_reg) + SQ_W'(sqy_reg);

    always_comb begin
        side3_next     = side2_reg;
        side3_next.hit = sq < SQ_W'(rs2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            radicand_reg <= (sq[SQ_W-1:RADICAND_W] != '0) ? '1 : sq[RADICAND_W-1:0];
            side3_reg    <= side3_next;
        end
    end

    logic [ROOT_W-1:0] len;
    ccp_root_side_t    side_sq_reg [SQRT_STAGES];

    ccp_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (radicand_reg),
        .root     (len)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            side_sq_reg[0] <= side3_reg;
            for (int i = 1; i < SQRT_STAGES; i++) begin
                side_sq_reg[i] <= side_sq_reg[i-1];
            end
        end
    end

    ccp_root_side_t    sidek_reg, sidem_reg;
    ccp_div_side_t     siden_reg;
    logic [RSUM_W-1:0] k_reg;
    logic [ROOT_W-1:0] lenk_reg, lenm_reg, lenn_reg;
    logic [PROD_W-1:0] px_prod_reg, py_prod_reg;
    logic [DIVIDEND_W-1:0] nx_reg, ny_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sidek_reg   <= side_sq_reg[SQRT_STAGES-1];
            k_reg       <= side_sq_reg[SQRT_STAGES-1].rsum - len;
            lenk_reg    <= len;
            sidem_reg   <= sidek_reg;
            lenm_reg    <= lenk_reg;
            px_prod_reg <= sidek_reg.ax * k_reg;
            py_prod_reg <= sidek_reg.ay * k_reg;
            siden_reg.neg_x <= sidem_reg.neg_x;
            siden_reg.neg_y <= sidem_reg.neg_y;
            siden_reg.hit   <= sidem_reg.hit;
            siden_reg.degen <= sidem_reg.degen;
            lenn_reg    <= lenm_reg;
            nx_reg      <= DIVIDEND_W'(px_prod_reg) + DIVIDEND_W'(lenm_reg >> 1);
            ny_reg      <= DIVIDEND_W'(py_prod_reg) + DIVIDEND_W'(lenm_reg >> 1);
        end
    end

    logic [QUOT_W-1:0] qx, qy;
    ccp_div_side_t     side_dv_reg [DIV_STAGES];

    ccp_div u_div_x (
        .aclk     (aclk),
        .en       (en),
        .dividend (nx_reg),
        .divisor  (lenn_reg),
        .quotient (qx)
    );

    ccp_div u_div_y (
        .aclk     (aclk),
        .en       (en),
        .dividend (ny_reg),
        .divisor  (lenn_reg),
        .quotient (qy)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            side_dv_reg[0] <= siden_reg;
            for (int i = 1; i < DIV_STAGES; i++) begin
                side_dv_reg[i] <= side_dv_reg[i-1];
            end
        end
    end

    ccp_div_side_t        side_end;
    logic                 push_ok;
    logic [PUSH_W-1:0]    mx, my;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TUSER_W-1:0] out_user_reg;

    assign side_end = side_dv_reg[DIV_STAGES-1];
    assign push_ok  = side_end.hit && !side_end.degen;
    assign mx = side_end.neg_x ? PUSH_W'(-{1'b0, qx}) : PUSH_W'({1'b0, qx});
    assign my = side_end.neg_y ? PUSH_W'(-{1'b0, qy}) : PUSH_W'({1'b0, qy});

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= M_TDATA_W'({(push_ok ? my : '0), (push_ok ? mx : '0)});
            out_user_reg <= {side_end.degen, side_end.hit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_tready) begin
                skid_full_reg <= 1'b0;
            end
        end else if (valid_reg[DEPTH-1] && !m_tready) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            skid_data_reg <= out_data_reg;
            skid_user_reg <= out_user_reg;
        end
    end

    assign m_tvalid = skid_full_reg || valid_reg[DEPTH-1];
    assign m_tdata  = skid_full_reg ? skid_data_reg : out_data_reg;
    assign m_tuser  = skid_full_reg ? skid_user_reg : out_user_reg;

`ifndef SYNTHESIS
    a_skid_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> m_tvalid)
        else $error("skid full without output valid");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (!skid_full_reg && valid_reg[DEPTH-1] && !m_tready) |=> skid_full_reg)
        else $error("stalled item not held in skid");

    a_no_hit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("push nonzero without collision");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == '0))
        else $error("push nonzero for coincident centres");

    a_valid_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && valid_reg[V_S3]) |=> valid_reg[V_S3+1])
        else $error("valid lost entering root pipeline");

    a_valid_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && valid_reg[V_SQ]) |=> valid_reg[V_SQ+1] || !$past(en) || valid_reg[V_N-2])
        else $error("valid lost after root pipeline");
`endif

endmodule

// ===== rtl/ccp_isqrt.sv =====
module ccp_isqrt
    import ccp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  en,
    input  logic [RADICAND_W-1:0] radicand,
    output logic [ROOT_W-1:0]     root
);

    logic [ROOT_W:0]         rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0]       root_reg [SQRT_STAGES];
    logic [RADICAND_W-1:0]   rad_reg  [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        logic [ROOT_W:0]       rem_in;
        logic [ROOT_W-1:0]     root_in;
        logic [RADICAND_W-1:0] rad_in;
        logic [ROOT_W+2:0]     shifted;
        logic [ROOT_W+2:0]     trial;
        logic [ROOT_W+2:0]     diff;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end else begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
        end

        always_comb begin
            shifted = {rem_in, rad_in[RADICAND_W-1 -: 2]};
            trial   = {1'b0, root_in, 2'b01};
            diff    = shifted - trial;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (shifted >= trial) begin
                    rem_reg[s]  <= diff[ROOT_W:0];
                    root_reg[s] <= {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[s]  <= shifted[ROOT_W:0];
                    root_reg[s] <= {root_in[ROOT_W-2:0], 1'b0};
                end
                rad_reg[s] <= {rad_in[RADICAND_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

// ===== rtl/ccp_div.sv =====
module ccp_div
    import ccp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  en,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [ROOT_W-1:0]     divisor,
    output logic [QUOT_W-1:0]     quotient
);

    logic [ROOT_W-1:0] rem_reg  [DIV_STAGES];
    logic [QUOT_W-1:0] quot_reg [DIV_STAGES];
    logic [QUOT_W-1:0] num_reg  [DIV_STAGES];
    logic [ROOT_W-1:0] den_reg  [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [ROOT_W-1:0] rem_in;
        logic [QUOT_W-1:0] quot_in;
        logic [QUOT_W-1:0] num_in;
        logic [ROOT_W-1:0] den_in;
        logic [ROOT_W:0]   shifted;
        logic [ROOT_W:0]   diff;

        if (s == 0) begin : g_first
            assign rem_in  = dividend[QUOT_W +: ROOT_W];
            assign quot_in = '0;
            assign num_in  = dividend[QUOT_W-1:0];
            assign den_in  = divisor;
        end else begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign quot_in = quot_reg[s-1];
            assign num_in  = num_reg[s-1];
            assign den_in  = den_reg[s-1];
        end

        always_comb begin
            shifted = {rem_in, num_in[QUOT_W-1]};
            diff    = shifted - {1'b0, den_in};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (shifted >= {1'b0, den_in}) begin
                    rem_reg[s]  <= diff[ROOT_W-1:0];
                    quot_reg[s] <= {quot_in[QUOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[s]  <= shifted[ROOT_W-1:0];
                    quot_reg[s] <= {quot_in[QUOT_W-2:0], 1'b0};
                end
                num_reg[s] <= {num_in[QUOT_W-2:0], 1'b0};
                den_reg[s] <= den_in;
            end
        end
    end

    assign quotient = quot_reg[DIV_STAGES-1];

endmodule
